// File: src/fp16rgb_pkg.sv
`timescale 1ns / 1ps

package fp16rgb_pkg;

    // Field widths.
    localparam int HALF_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 2;

    typedef logic [HALF_W-1:0]  t_half;
    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [COUNT_W-1:0] t_chan_count;

    // Half-precision field layout and codes.
    localparam int          EXP_W     = 5;
    localparam int          FRAC_W    = 10;
    localparam logic [4:0]  EXP_SPEC  = 5'h1f;  // infinity or NaN
    localparam logic [4:0]  EXP_ONE   = 5'd15;  // 1.0 and above saturate
    localparam logic [4:0]  EXP_BIAS  = 5'd25;  // shift is EXP_BIAS - exponent

    // Width of the scaled significand plus rounding term.
    localparam int PROD_W = 25;

    localparam t_byte BYTE_MAX  = 8'hff;
    localparam t_byte BYTE_ZERO = 8'h00;

    // Channel count codes and the minimum count that enables each channel.
    localparam t_chan_count CHAN_CNT_RESET = 2'd3;
    localparam t_chan_count CHAN_MIN_RED   = 2'd1;
    localparam t_chan_count CHAN_MIN_GREEN = 2'd2;
    localparam t_chan_count CHAN_MIN_BLUE  = 2'd3;

endpackage

// File: src/fp16rgb_if.sv
`timescale 1ns / 1ps

// Pixel channel: three half-precision values and a frame end mark.
interface fp16rgb_pix_if;
    import fp16rgb_pkg::*;

    logic  valid;
    logic  ready;
    t_half red_half;
    t_half green_half;
    t_half blue_half;
    logic  frame_end;

    modport source (output valid, red_half, green_half, blue_half, frame_end, input ready);
    modport sink   (input valid, red_half, green_half, blue_half, frame_end, output ready);
endinterface

// Byte channel: three packed color bytes and the frame end mark.
interface fp16rgb_byte_if;
    import fp16rgb_pkg::*;

    logic  valid;
    logic  ready;
    t_byte red_byte;
    t_byte green_byte;
    t_byte blue_byte;
    logic  frame_end_out;

    modport source (output valid, red_byte, green_byte, blue_byte, frame_end_out, input ready);
    modport sink   (input valid, red_byte, green_byte, blue_byte, frame_end_out, output ready);
endinterface

// File: src/fp16rgb_half_conv.sv
`timescale 1ns / 1ps

// Converts one half-precision value to an unsigned byte: the value times
// 255, rounded half up and clamped to 0..255. Purely combinational.
module fp16rgb_half_conv (
    input  fp16rgb_pkg::t_half i_half,
    output fp16rgb_pkg::t_byte o_byte
);
    import fp16rgb_pkg::*;

    logic              w_sign;
    logic [EXP_W-1:0]  w_expf;
    logic [FRAC_W-1:0] w_frac;
    logic [FRAC_W:0]   w_sig;
    logic [EXP_W-1:0]  w_ex;
    logic [EXP_W-1:0]  w_shift;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] w_round;
    logic [PROD_W-1:0] w_sum;
    logic [PROD_W-1:0] w_scaled;

    assign w_sign = i_half[HALF_W-1];
    assign w_expf = i_half[HALF_W-2 -: EXP_W];
    assign w_frac = i_half[FRAC_W-1:0];

    // Integer significand and effective exponent; subnormals use exponent 1.
    assign w_sig   = (w_expf != '0) ? {1'b1, w_frac} : {1'b0, w_frac};
    assign w_ex    = (w_expf != '0) ? w_expf : EXP_W'(1);
    assign w_shift = EXP_BIAS - w_ex;

    // Significand times 255 as (s << 8) - s, then add half an output LSB.
    assign w_prod   = (PROD_W'(w_sig) << 8) - PROD_W'(w_sig);
    assign w_round  = PROD_W'(1) << (w_shift - EXP_W'(1));
    assign w_sum    = w_prod + w_round;
    assign w_scaled = w_sum >> w_shift;

    // Special values first, then the clamped fixed-point result.
    always_comb begin
        if (w_expf == EXP_SPEC) begin
            o_byte = (w_frac != '0 || w_sign) ? BYTE_ZERO : BYTE_MAX;
        end else if (w_sign) begin
            o_byte = BYTE_ZERO;
        end else if (w_expf >= EXP_ONE) begin
            o_byte = BYTE_MAX;
        end else if (w_scaled > PROD_W'(BYTE_MAX)) begin
            o_byte = BYTE_MAX;
        end else begin
            o_byte = w_scaled[BYTE_W-1:0];
        end
    end

endmodule

// File: src/fp16_planar_to_rgb_byte_packer_core.sv
`timescale 1ns / 1ps

// Half-precision pixel to RGB byte packer.
// i_pix carries one pixel per transaction as three half-precision values
// plus a frame end mark; o_byte returns one transaction per pixel with the
// three converted bytes and the copied frame end mark, in order.
// Each value becomes min(255, round-half-up(x * 255)); negatives, zero and
// NaN give 0, while 1.0 and above and +infinity give 255.
// The channel count register (i_cfg_wr_en, i_cfg_wr_data) zeroes the
// channels at and above the count; write it only while the block is idle.
// A pixel passes from input acceptance to o_byte.valid through one input
// register and one result register with the conversion between them.
// Throughput is one pixel per cycle when o_byte does not stall, set by the
// single conversion stage. When the receiver stalls, the result register
// holds its transaction and the input register keeps accepting until it is
// also full; i_pix.ready then drops until o_byte.ready returns.
// Reset (synchronous, active low) empties both stages and sets the channel
// count to 3.
module fp16_planar_to_rgb_byte_packer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  fp16rgb_pkg::t_chan_count    i_cfg_wr_data,
    fp16rgb_pix_if.sink                 i_pix,
    fp16rgb_byte_if.source              o_byte
);
    import fp16rgb_pkg::*;

    t_chan_count r_chan_cnt;

    logic  r_s1_valid;
    t_half r_s1_red;
    t_half r_s1_green;
    t_half r_s1_blue;
    logic  r_s1_frame_end;

    logic  r_out_valid;
    t_byte r_out_red;
    t_byte r_out_green;
    t_byte r_out_blue;
    logic  r_out_frame_end;

    t_byte w_red;
    t_byte w_green;
    t_byte w_blue;
    t_byte n_out_red;
    t_byte n_out_green;
    t_byte n_out_blue;

    logic w_out_load;
    logic w_s1_load;

    // Stage enables: each stage loads when it is empty or the next one moves.
    assign w_out_load  = !r_out_valid || o_byte.ready;
    assign w_s1_load   = !r_s1_valid || w_out_load;
    assign i_pix.ready = w_s1_load;

    // Channel count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt <= CHAN_CNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_chan_cnt <= i_cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_load) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load && i_pix.valid) begin
            r_s1_red       <= i_pix.red_half;
            r_s1_green     <= i_pix.green_half;
            r_s1_blue      <= i_pix.blue_half;
            r_s1_frame_end <= i_pix.frame_end;
        end
    end

    // One converter per color channel.
    fp16rgb_half_conv u_conv_red (
        .i_half (r_s1_red),
        .o_byte (w_red)
    );

    fp16rgb_half_conv u_conv_green (
        .i_half (r_s1_green),
        .o_byte (w_green)
    );

    fp16rgb_half_conv u_conv_blue (
        .i_half (r_s1_blue),
        .o_byte (w_blue)
    );

    // Zero the channels that the channel count leaves unused.
    assign n_out_red   = (r_chan_cnt >= CHAN_MIN_RED)   ? w_red   : BYTE_ZERO;
    assign n_out_green = (r_chan_cnt >= CHAN_MIN_GREEN) ? w_green : BYTE_ZERO;
    assign n_out_blue  = (r_chan_cnt >= CHAN_MIN_BLUE)  ? w_blue  : BYTE_ZERO;

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load && r_s1_valid) begin
            r_out_red       <= n_out_red;
            r_out_green     <= n_out_green;
            r_out_blue      <= n_out_blue;
            r_out_frame_end <= r_s1_frame_end;
        end
    end

    assign o_byte.valid         = r_out_valid;
    assign o_byte.red_byte      = r_out_red;
    assign o_byte.green_byte    = r_out_green;
    assign o_byte.blue_byte     = r_out_blue;
    assign o_byte.frame_end_out = r_out_frame_end;

endmodule

// File: dv/fp16rgb_checker.sv
`timescale 1ns / 1ps

// Watches the pixel and byte channels, predicts each byte transaction from
// the accepted pixel transaction and its own copy of the channel count, and
// compares the two in order.
module fp16rgb_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  fp16rgb_pkg::t_chan_count   i_cfg_wr_data,
    fp16rgb_pix_if                     pix,
    fp16rgb_byte_if                    res,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);
    import fp16rgb_pkg::*;

    typedef struct packed {
        t_byte red;
        t_byte green;
        t_byte blue;
        logic  frame_end;
    } t_rgb_bytes;

    t_rgb_bytes  rgb_bytes_q[$];
    t_chan_count chan_count_shadow;

    // Half to unsigned byte: scale by 255 in fixed point, round half up,
    // clamp. Negatives and NaN give zero; 1.0 and above give 255.
    function automatic t_byte half_to_unorm8(input t_half h);
        logic        neg;
        logic [4:0]  exp_field;
        logic [9:0]  frac_field;
        logic [31:0] mant;
        logic [31:0] scaled;
        int unsigned shift;
        neg        = h[15];
        exp_field  = h[14:10];
        frac_field = h[9:0];
        if (exp_field == EXP_SPEC) begin
            return (frac_field == '0 && !neg) ? BYTE_MAX : BYTE_ZERO;
        end
        if (neg) begin
            return BYTE_ZERO;
        end
        if (exp_field >= EXP_ONE) begin
            return BYTE_MAX;
        end
        mant   = (exp_field != '0) ? {21'd0, 1'b1, frac_field} : {22'd0, frac_field};
        shift  = 25 - ((exp_field != '0) ? int'(exp_field) : 1);
        scaled = (mant * 32'd255 + (32'd1 << (shift - 1))) >> shift;
        return (scaled > 32'd255) ? BYTE_MAX : scaled[7:0];
    endfunction

    function automatic t_rgb_bytes pack_pixel(input t_half r, input t_half g,
                                              input t_half b, input logic fe,
                                              input t_chan_count cnt);
        t_rgb_bytes px;
        px.red       = (cnt >= CHAN_MIN_RED)   ? half_to_unorm8(r) : BYTE_ZERO;
        px.green     = (cnt >= CHAN_MIN_GREEN) ? half_to_unorm8(g) : BYTE_ZERO;
        px.blue      = (cnt >= CHAN_MIN_BLUE)  ? half_to_unorm8(b) : BYTE_ZERO;
        px.frame_end = fe;
        return px;
    endfunction

    // Track the register, queue predictions and compare results at each edge.
    always @(posedge i_clk) begin
        t_rgb_bytes want;
        if (!i_rst_n) begin
            chan_count_shadow = CHAN_CNT_RESET;
            rgb_bytes_q.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_cfg_wr_en) begin
                chan_count_shadow = i_cfg_wr_data;
            end
            if (res.valid && res.ready) begin
                if (rgb_bytes_q.size() == 0) begin
                    $error("unexpected byte transaction: red %0d green %0d blue %0d",
                           res.red_byte, res.green_byte, res.blue_byte);
                    o_fail_count++;
                end else begin
                    want = rgb_bytes_q.pop_front();
                    o_checked++;
                    if (res.red_byte !== want.red) begin
                        $error("red_byte: expected %0d, actual %0d", want.red, res.red_byte);
                        o_fail_count++;
                    end
                    if (res.green_byte !== want.green) begin
                        $error("green_byte: expected %0d, actual %0d",
                               want.green, res.green_byte);
                        o_fail_count++;
                    end
                    if (res.blue_byte !== want.blue) begin
                        $error("blue_byte: expected %0d, actual %0d", want.blue, res.blue_byte);
                        o_fail_count++;
                    end
                    if (res.frame_end_out !== want.frame_end) begin
                        $error("frame_end_out: expected %0d, actual %0d",
                               want.frame_end, res.frame_end_out);
                        o_fail_count++;
                    end
                end
            end
            if (pix.valid && pix.ready) begin
                rgb_bytes_q.insert(rgb_bytes_q.size(),
                                   pack_pixel(pix.red_half, pix.green_half, pix.blue_half,
                                              pix.frame_end, chan_count_shadow));
            end
        end
        o_pending = rgb_bytes_q.size();
    end

endmodule

// File: dv/tb_fp16_planar_to_rgb_byte_packer_core.sv
`timescale 1ns / 1ps

module tb_fp16_planar_to_rgb_byte_packer_core;
    import fp16rgb_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LONG_STALL    = 80;
    localparam int STALL_AT      = 250;
    localparam int NUM_PHASES    = 6;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_wr_en;
    t_chan_count cfg_wr_data;

    fp16rgb_pix_if  pix_ch();
    fp16rgb_byte_if byte_ch();

    int   fail_count;
    int   pending;
    int   checked;
    int   cycles;
    int   pixels_sent;
    bit   idle_on;
    bit   long_stall_done;

    // Special half values for the directed part and for random picks.
    t_half special_halves[16] = '{
        16'h0000, 16'h8000, 16'h3c00, 16'h7c00, 16'hfc00, 16'h7e00, 16'hfe00, 16'h0001,
        16'h03ff, 16'h0400, 16'h3bff, 16'h7bff, 16'hffff, 16'h3800, 16'h7fff, 16'h1c00
    };

    // Channel count and item count of each random phase; the last one runs
    // without idling.
    t_chan_count phase_count[NUM_PHASES] = '{2'd0, 2'd2, 2'd1, 2'd3, 2'd2, 2'd3};
    int          phase_items[NUM_PHASES] = '{60, 80, 80, 150, 60, 110};

    fp16_planar_to_rgb_byte_packer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_pix         (pix_ch),
        .o_byte        (byte_ch)
    );

    fp16rgb_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .pix           (pix_ch),
        .res           (byte_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Random half value, weighted toward the region that converts to
    // something other than 0 or 255.
    function automatic t_half pick_half();
        t_half h;
        case ($urandom_range(0, 9)) inside
            [0:2]: h = 16'($urandom);
            [3:6]: h = {1'b0, 5'($urandom_range(0, 14)), 10'($urandom)};
            7: h = {1'b0, 5'($urandom_range(13, 15)), 10'($urandom)};
            8: h = special_halves[$urandom_range(0, 15)];
            default: h = {1'b0, 5'd0, 10'($urandom)};
        endcase
        return h;
    endfunction

    // One pixel transaction, with an optional idle burst in front of it.
    task automatic send_pixel(input t_half r, input t_half g, input t_half b,
                              input logic fe);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        pix_ch.valid      <= 1'b1;
        pix_ch.red_half   <= r;
        pix_ch.green_half <= g;
        pix_ch.blue_half  <= b;
        pix_ch.frame_end  <= fe;
        do @(posedge i_clk); while (!pix_ch.ready);
        @(negedge i_clk);
        pixels_sent++;
    endtask

    // Wait for the block to go idle, then write the channel count.
    task automatic write_chan_count(input t_chan_count cnt);
        pix_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cnt;
        @(negedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Receiver: random back-pressure bursts and one long hold-off.
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (!long_stall_done && checked >= STALL_AT) begin
                byte_ch.ready <= 1'b0;
                repeat (LONG_STALL) @(negedge i_clk);
                long_stall_done = 1'b1;
                byte_ch.ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
                byte_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                hold = $urandom_range(1, 15) - 1;
                byte_ch.ready <= 1'b0;
            end else begin
                byte_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus: reset, directed pixels, then random phases at each count.
    initial begin
        int n;
        pix_ch.valid      = 1'b0;
        pix_ch.red_half   = '0;
        pix_ch.green_half = '0;
        pix_ch.blue_half  = '0;
        pix_ch.frame_end  = 1'b0;
        byte_ch.ready     = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        i_rst_n           = 1'b0;
        cycles            = 0;
        pixels_sent       = 0;
        idle_on           = 1'b1;
        long_stall_done   = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset channel count: each special value in
        // every color position, frame end toggling.
        n = $size(special_halves);
        for (int i = 0; i < n; i++) begin
            send_pixel(special_halves[i], special_halves[(i + 1) % n],
                       special_halves[(i + 2) % n], i[0]);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_chan_count(phase_count[p]);
            if (p == NUM_PHASES - 1) begin
                idle_on = 1'b0;
            end
            for (int i = 0; i < phase_items[p]; i++) begin
                send_pixel(pick_half(), pick_half(), pick_half(), 1'($urandom));
            end
        end

        // Drain and give the verdict.
        pix_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Sent %0d pixels over channel counts 0 to 3, including special halves,",
                 pixels_sent);
        $display("random back-pressure and a long receiver stall; %0d results compared.",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
